>>> hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Lexical scan modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SQUOTE = 3'd1,
    MODE_DQUOTE = 3'd2,
    MODE_SLASH  = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5,
    MODE_STAR   = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // Bracket kinds as stored on the stack
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SQUARE = 2'd0;
  localparam kind_t KIND_ROUND  = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LSQUARE = 8'h5B;  // [
  localparam logic [7:0] CH_RSQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_LROUND  = 8'h28;  // (
  localparam logic [7:0] CH_RROUND  = 8'h29;  // )
  localparam logic [7:0] CH_LCURLY  = 8'h7B;  // {
  localparam logic [7:0] CH_RCURLY  = 8'h7D;  // }
  localparam logic [7:0] CH_SLASH   = 8'h2F;  // /
  localparam logic [7:0] CH_STAR    = 8'h2A;  // *
  localparam logic [7:0] CH_SQUOTE  = 8'h27;  // '
  localparam logic [7:0] CH_DQUOTE  = 8'h22;  // "
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Stack operation requested by the lexer
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stack_op_t;

  // Stack status seen by the control logic
  typedef struct packed {
    logic  empty;
    logic  full;
    kind_t top_kind;
    logic  busy_after;  // stack non-empty after this cycle's operation
  } stack_stat_t;

endpackage

>>> hw/rtl/bbc_if.sv
// ----------------------------------------------------------------------------
// bbc_in_if / bbc_out_if
// Valid/ready channels for text bytes and check results.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        balanced;
  logic [31:0] line_count;
  logic [31:0] char_count;

  modport source (output valid, output status, output balanced, output line_count,
                  output char_count, input ready);
  modport sink   (input valid, input status, input balanced, input line_count,
                  input char_count, output ready);
endinterface

>>> hw/rtl/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bbc_lexer.sv
// ----------------------------------------------------------------------------
// bbc_lexer
// Next scan mode and bracket stack operation for one text byte.
// ----------------------------------------------------------------------------
module bbc_lexer (
  input  bbc_pkg::mode_e     mode_i,
  input  logic [7:0]         text_byte_i,
  output bbc_pkg::mode_e     mode_o,
  output bbc_pkg::stack_op_t op_o
);

  logic as_normal;

  always_comb begin
    mode_o    = mode_i;
    as_normal = 1'b0;
    unique case (mode_i)
      bbc_pkg::MODE_SQUOTE: begin
        if (text_byte_i == bbc_pkg::CH_SQUOTE) mode_o = bbc_pkg::MODE_NORMAL;
      end
      bbc_pkg::MODE_DQUOTE: begin
        if (text_byte_i == bbc_pkg::CH_DQUOTE) mode_o = bbc_pkg::MODE_NORMAL;
      end
      bbc_pkg::MODE_SLASH: begin
        if (text_byte_i == bbc_pkg::CH_SLASH) begin
          mode_o = bbc_pkg::MODE_LINE;
        end else if (text_byte_i == bbc_pkg::CH_STAR) begin
          mode_o = bbc_pkg::MODE_BLOCK;
        end else begin
          // lone slash: byte is handled as plain text
          as_normal = 1'b1;
        end
      end
      bbc_pkg::MODE_LINE: begin
        if (text_byte_i == bbc_pkg::CH_NEWLINE) mode_o = bbc_pkg::MODE_NORMAL;
      end
      bbc_pkg::MODE_BLOCK: begin
        if (text_byte_i == bbc_pkg::CH_STAR) mode_o = bbc_pkg::MODE_STAR;
      end
      bbc_pkg::MODE_STAR: begin
        if (text_byte_i == bbc_pkg::CH_SLASH) begin
          mode_o = bbc_pkg::MODE_NORMAL;
        end else if (text_byte_i != bbc_pkg::CH_STAR) begin
          mode_o = bbc_pkg::MODE_BLOCK;
        end
      end
      default: begin
        as_normal = 1'b1;
      end
    endcase

    op_o = '{push: 1'b0, pop: 1'b0, kind: bbc_pkg::KIND_SQUARE};
    if (as_normal) begin
      mode_o = bbc_pkg::MODE_NORMAL;
      case (text_byte_i)
        bbc_pkg::CH_SQUOTE:  mode_o = bbc_pkg::MODE_SQUOTE;
        bbc_pkg::CH_DQUOTE:  mode_o = bbc_pkg::MODE_DQUOTE;
        bbc_pkg::CH_SLASH:   mode_o = bbc_pkg::MODE_SLASH;
        bbc_pkg::CH_LSQUARE: op_o = '{push: 1'b1, pop: 1'b0, kind: bbc_pkg::KIND_SQUARE};
        bbc_pkg::CH_LROUND:  op_o = '{push: 1'b1, pop: 1'b0, kind: bbc_pkg::KIND_ROUND};
        bbc_pkg::CH_LCURLY:  op_o = '{push: 1'b1, pop: 1'b0, kind: bbc_pkg::KIND_CURLY};
        bbc_pkg::CH_RSQUARE: op_o = '{push: 1'b0, pop: 1'b1, kind: bbc_pkg::KIND_SQUARE};
        bbc_pkg::CH_RROUND:  op_o = '{push: 1'b0, pop: 1'b1, kind: bbc_pkg::KIND_ROUND};
        bbc_pkg::CH_RCURLY:  op_o = '{push: 1'b0, pop: 1'b1, kind: bbc_pkg::KIND_CURLY};
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/bbc_stack.sv
// ----------------------------------------------------------------------------
// bbc_stack
// Bounded bracket stack: top entry in a register, the rest in RAM, with the
// entry under the top prefetched so pops can follow one another back to back.
// ----------------------------------------------------------------------------
module bbc_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,   // apply op_i this cycle
  input  logic                 clear_i,  // return to empty after this cycle
  input  bbc_pkg::stack_op_t   op_i,
  output bbc_pkg::stack_stat_t stat_o
);

  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int LvlW = $clog2(STACK_DEPTH + 1);

  logic [LvlW-1:0]      level_q, level_step, level_d, raddr_full;
  bbc_pkg::kind_t       top_q, top_d, below;
  logic                 empty, full, do_push, do_pop;

  assign empty   = (level_q == '0);
  assign full    = (level_q == LvlW'(STACK_DEPTH));
  assign do_push = step_i && op_i.push && !full;
  assign do_pop  = step_i && op_i.pop && !empty;

  always_comb begin
    level_step = level_q;
    top_d      = top_q;
    if (do_push) begin
      level_step = level_q + LvlW'(1);
      top_d      = op_i.kind;
    end else if (do_pop) begin
      level_step = level_q - LvlW'(1);
      top_d      = below;
    end
    level_d = clear_i ? '0 : level_step;
  end

  // read the entry that sits under the top after this cycle
  assign raddr_full = level_d - LvlW'(2);

  bbc_ram #(
    .WIDTH ($bits(bbc_pkg::kind_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (level_q[IdxW-1:0]),
    .wdata_i (op_i.kind),
    .raddr_i (raddr_full[IdxW-1:0]),
    .rdata_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  assign stat_o = '{empty: empty, full: full, top_kind: top_q,
                    busy_after: (level_step != '0)};

endmodule

>>> hw/rtl/bracket_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Streaming bracket balance check over source text with quote and comment
// skipping, sticky first error and saturating line/byte counts.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one text byte per transaction; end_of_text marks the last
//   byte of a text. result_o carries one transaction per text: status,
//   balanced flag, line count and byte count.
//   Throughput is one byte per cycle while no last byte is held off. Each byte
//   accepted before an error updates scan mode, counters and the stack top in
//   the cycle it is accepted; the result appears on result_o in the cycle after
//   the last byte is accepted. The stack keeps its top in a register and the
//   next entry prefetched from RAM, so back-to-back pops need no wait.
//   A waiting result does not stall ordinary bytes; only a last byte is held
//   off while the previous result is still not taken by the receiver.
//   After the last byte, scan mode, stack, error and counters are back in their
//   reset state, so the next text may start in the following cycle.
//   Reset (rst_ni low) clears scan mode, stack level, error and counters and
//   drops any pending result. Stack RAM contents need no clearing.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    text_i,
  bbc_out_if.source result_o
);

  bbc_pkg::mode_e       mode_q, mode_next;
  bbc_pkg::status_e     err_q, err_next, status_d;
  bbc_pkg::stack_op_t   op;
  bbc_pkg::stack_stat_t stk;
  logic [31:0]          lines_q, lines_next, bytes_q, bytes_next;
  logic                 accept, active, last;
  logic                 out_valid_q;
  logic [2:0]           status_q;
  logic                 balanced_q;
  logic [31:0]          line_cnt_q, char_cnt_q;

  assign text_i.ready = !out_valid_q || result_o.ready || !text_i.end_of_text;
  assign accept       = text_i.valid && text_i.ready;
  assign last         = text_i.end_of_text;
  assign active       = (err_q == bbc_pkg::ST_OK);

  bbc_lexer u_lexer (
    .mode_i      (mode_q),
    .text_byte_i (text_i.text_byte),
    .mode_o      (mode_next),
    .op_o        (op)
  );

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept && active),
    .clear_i (accept && last),
    .op_i    (op),
    .stat_o  (stk)
  );

  always_comb begin
    err_next   = err_q;
    lines_next = lines_q;
    bytes_next = bytes_q;
    if (active) begin
      if (text_i.text_byte == bbc_pkg::CH_NEWLINE && lines_q != bbc_pkg::COUNT_MAX) begin
        lines_next = lines_q + 32'd1;
      end
      if (bytes_q != bbc_pkg::COUNT_MAX) begin
        bytes_next = bytes_q + 32'd1;
      end
      if (op.push && stk.full) begin
        err_next = bbc_pkg::ST_OVERFLOW;
      end else if (op.pop && stk.empty) begin
        err_next = bbc_pkg::ST_EMPTY;
      end else if (op.pop && stk.top_kind != op.kind) begin
        err_next = bbc_pkg::ST_MISMATCH;
      end
    end

    status_d = err_next;
    if (err_next == bbc_pkg::ST_OK && stk.busy_after) begin
      status_d = bbc_pkg::ST_UNCLOSED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= bbc_pkg::MODE_NORMAL;
      err_q       <= bbc_pkg::ST_OK;
      lines_q     <= 32'd1;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if (accept && last) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          mode_q      <= bbc_pkg::MODE_NORMAL;
          err_q       <= bbc_pkg::ST_OK;
          lines_q     <= 32'd1;
          bytes_q     <= '0;
        end else if (active) begin
          mode_q  <= mode_next;
          err_q   <= err_next;
          lines_q <= lines_next;
          bytes_q <= bytes_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      status_q   <= status_d;
      balanced_q <= (status_d == bbc_pkg::ST_OK);
      line_cnt_q <= lines_next;
      char_cnt_q <= bytes_next;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.status     = status_q;
  assign result_o.balanced   = balanced_q;
  assign result_o.line_count = line_cnt_q;
  assign result_o.char_count = char_cnt_q;

endmodule
